// ===== rtl/ac3sf_pkg.sv =====
// ac3sf_pkg: shared types, constants and frame length tables of the ac-3 sync frame splitter
`timescale 1ns / 1ps
package ac3sf_pkg;

  localparam logic [7:0] SYNC_BYTE0 = 8'h0B;
  localparam logic [7:0] SYNC_BYTE1 = 8'h77;

  localparam logic [1:0] EV_DONE = 2'd0;
  localparam logic [1:0] EV_BAD  = 2'd1;
  localparam logic [1:0] EV_BIG  = 2'd2;

  localparam logic [1:0] RATE_48K      = 2'd0;
  localparam logic [1:0] RATE_44K      = 2'd1;
  localparam logic [1:0] RATE_RESERVED = 2'd3;

  localparam logic [5:0]  SIZE_CODE_LAST    = 6'd37;
  localparam logic [15:0] BLOCK_LIMIT_RESET = 16'd3840;
  localparam logic [15:0] LEAD_REPORT_MAX   = 16'hFFFF;
  localparam logic [2:0]  HEADER_LAST_POS   = 3'd4;
  localparam logic [11:0] HEADER_BYTES      = 12'd5;

  // frame sizes in 16-bit words per frmsizecod
  localparam logic [10:0] WORDS_48K [0:37] = '{
    11'd64, 11'd64, 11'd80, 11'd80, 11'd96, 11'd96, 11'd112, 11'd112,
    11'd128, 11'd128, 11'd160, 11'd160, 11'd192, 11'd192, 11'd224, 11'd224,
    11'd256, 11'd256, 11'd320, 11'd320, 11'd384, 11'd384, 11'd448, 11'd448,
    11'd512, 11'd512, 11'd640, 11'd640, 11'd768, 11'd768, 11'd896, 11'd896,
    11'd1024, 11'd1024, 11'd1152, 11'd1152, 11'd1280, 11'd1280};

  localparam logic [10:0] WORDS_44K [0:37] = '{
    11'd69, 11'd70, 11'd87, 11'd88, 11'd104, 11'd105, 11'd121, 11'd122,
    11'd139, 11'd140, 11'd174, 11'd175, 11'd208, 11'd209, 11'd243, 11'd244,
    11'd278, 11'd279, 11'd348, 11'd349, 11'd417, 11'd418, 11'd487, 11'd488,
    11'd557, 11'd558, 11'd696, 11'd697, 11'd835, 11'd836, 11'd975, 11'd976,
    11'd1114, 11'd1115, 11'd1253, 11'd1254, 11'd1393, 11'd1394};

  localparam logic [10:0] WORDS_32K [0:37] = '{
    11'd96, 11'd96, 11'd120, 11'd120, 11'd144, 11'd144, 11'd168, 11'd168,
    11'd192, 11'd192, 11'd240, 11'd240, 11'd288, 11'd288, 11'd336, 11'd336,
    11'd384, 11'd384, 11'd480, 11'd480, 11'd576, 11'd576, 11'd672, 11'd672,
    11'd768, 11'd768, 11'd960, 11'd960, 11'd1152, 11'd1152, 11'd1344, 11'd1344,
    11'd1536, 11'd1536, 11'd1728, 11'd1728, 11'd1920, 11'd1920};

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] lead_bytes;
    logic [11:0] frame_bytes;
    logic [1:0]  rate_code;
    logic [5:0]  size_code;
  } result_t;

  // frame length in bytes; caller keeps size code within the table
  function automatic logic [11:0] frame_length(input logic [1:0] rate, input logic [5:0] size);
    logic [10:0] words;
    case (rate)
      RATE_48K: words = WORDS_48K[size];
      RATE_44K: words = WORDS_44K[size];
      default:  words = WORDS_32K[size];
    endcase
    return {words, 1'b0};
  endfunction

endpackage

// ===== rtl/ac3sf_in_stage.sv =====
// ac3sf_in_stage: input byte register with stall control
`timescale 1ns / 1ps
module ac3sf_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       out_room,
  output logic       step,
  output logic [7:0] byte_q
);

  logic held;

  // the held byte moves on whenever the result side has room
  assign step     = held & out_room;
  assign in_ready = ~held | step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
    end
  end

endmodule

// ===== rtl/ac3sf_parser.sv =====
// ac3sf_parser: sync hunt, header decode and frame count state machine
`timescale 1ns / 1ps
module ac3sf_parser #(
  parameter int unsigned LEAD_COUNT_MAX = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [15:0]          cfg_wr_data,
  input  logic                 step,
  input  logic [7:0]           byte_q,
  output logic                 emit,
  output ac3sf_pkg::result_t   result
);
  import ac3sf_pkg::*;

  localparam int unsigned LEAD_W = $clog2(LEAD_COUNT_MAX + 1);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_BODY   = 2'd2;

  logic [15:0]       max_block_bytes;
  logic [1:0]        phase, phase_next;
  logic              saw_first_sync, saw_first_sync_next;
  logic [2:0]        header_position, header_position_next;
  logic [LEAD_W-1:0] lead_count, lead_count_next;
  logic [11:0]       bytes_left, bytes_left_next;
  logic [11:0]       held_frame_length, held_frame_length_next;
  logic [7:0]        held_codes, held_codes_next;

  logic [31:0]       lead_ext, lead_plus1, lead_plus2;
  logic [LEAD_W-1:0] lead_sat1, lead_sat2;
  logic [1:0]        rate;
  logic [5:0]        size;
  logic              bad_header;
  logic [11:0]       frame_len;
  logic [11:0]       left_dec;
  logic [15:0]       lead_report;

  assign lead_ext   = 32'(lead_count);
  assign lead_plus1 = lead_ext + 32'd1;
  assign lead_plus2 = lead_ext + 32'd2;
  assign lead_sat1  = (lead_plus1 > 32'(LEAD_COUNT_MAX)) ? LEAD_W'(LEAD_COUNT_MAX)
                                                         : LEAD_W'(lead_plus1);
  assign lead_sat2  = (lead_plus2 > 32'(LEAD_COUNT_MAX)) ? LEAD_W'(LEAD_COUNT_MAX)
                                                         : LEAD_W'(lead_plus2);
  assign lead_report = (lead_ext > 32'(LEAD_REPORT_MAX)) ? LEAD_REPORT_MAX
                                                         : lead_ext[15:0];

  assign rate       = byte_q[7:6];
  assign size       = byte_q[5:0];
  assign bad_header = (rate == RATE_RESERVED) || (size > SIZE_CODE_LAST);
  // reserved size codes read entry zero, the result is dropped anyway
  assign frame_len  = frame_length(rate, bad_header ? 6'd0 : size);
  assign left_dec   = bytes_left - {11'd0, (bytes_left != 12'd0)};

  always_comb begin
    phase_next             = phase;
    saw_first_sync_next    = saw_first_sync;
    header_position_next   = header_position;
    lead_count_next        = lead_count;
    bytes_left_next        = bytes_left;
    held_frame_length_next = held_frame_length;
    held_codes_next        = held_codes;
    emit                   = 1'b0;
    result.event_kind      = EV_DONE;
    result.lead_bytes      = lead_report;
    result.frame_bytes     = held_frame_length;
    result.rate_code       = held_codes[7:6];
    result.size_code       = held_codes[5:0];

    case (phase)
      PH_HUNT: begin
        if (saw_first_sync) begin
          if (byte_q == SYNC_BYTE1) begin
            phase_next           = PH_HEADER;
            header_position_next = 3'd1;
            saw_first_sync_next  = 1'b0;
          end else if (byte_q == SYNC_BYTE0) begin
            // the new 0x0b may still start the sync word
            lead_count_next = lead_sat1;
          end else begin
            lead_count_next     = lead_sat2;
            saw_first_sync_next = 1'b0;
          end
        end else if (byte_q == SYNC_BYTE0) begin
          saw_first_sync_next = 1'b1;
        end else begin
          lead_count_next = lead_sat1;
        end
      end
      PH_HEADER: begin
        header_position_next = header_position + 3'd1;
        if (header_position_next == HEADER_LAST_POS) begin
          result.rate_code = rate;
          result.size_code = size;
          if (bad_header) begin
            emit               = 1'b1;
            result.event_kind  = EV_BAD;
            result.frame_bytes = 12'd0;
          end else begin
            held_frame_length_next = frame_len;
            held_codes_next        = byte_q;
            if (lead_ext + 32'(frame_len) > 32'(max_block_bytes)) begin
              emit               = 1'b1;
              result.event_kind  = EV_BIG;
              result.frame_bytes = frame_len;
            end else begin
              bytes_left_next      = frame_len - HEADER_BYTES;
              phase_next           = PH_BODY;
              header_position_next = 3'd0;
            end
          end
        end
      end
      default: begin
        bytes_left_next = left_dec;
        if (left_dec == 12'd0) begin
          emit = 1'b1;
        end
      end
    endcase

    // every event sends the block back to hunting
    if (emit) begin
      phase_next           = PH_HUNT;
      saw_first_sync_next  = 1'b0;
      header_position_next = 3'd0;
      lead_count_next      = '0;
      bytes_left_next      = 12'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_block_bytes <= BLOCK_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_block_bytes <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HUNT;
      saw_first_sync    <= 1'b0;
      header_position   <= 3'd0;
      lead_count        <= '0;
      bytes_left        <= 12'd0;
      held_frame_length <= 12'd0;
      held_codes        <= 8'd0;
    end else if (step) begin
      phase             <= phase_next;
      saw_first_sync    <= saw_first_sync_next;
      header_position   <= header_position_next;
      lead_count        <= lead_count_next;
      bytes_left        <= bytes_left_next;
      held_frame_length <= held_frame_length_next;
      held_codes        <= held_codes_next;
    end
  end

endmodule

// ===== rtl/ac3sf_out_stage.sv =====
// ac3sf_out_stage: result register with valid/ready output
`timescale 1ns / 1ps
module ac3sf_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ac3sf_pkg::result_t result,
  output logic               out_room,
  output logic               out_valid,
  input  logic               out_ready,
  output ac3sf_pkg::result_t result_q
);
  import ac3sf_pkg::*;

  assign out_room = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_q <= result;
    end
  end

endmodule

// ===== rtl/ac3_syncframe_splitter.sv =====
// ac3_syncframe_splitter: top level of the ac-3 sync frame splitter
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | in        | in_valid / in_ready  | data_byte
//   out     | out       | out_valid / out_ready| event_kind lead_bytes frame_bytes
//           |           |                      | rate_code size_code
//   cfg     | in        | cfg_wr_en            | cfg_wr_data (max_block_bytes)
//
// one byte per cycle sustained while the result register has room; a byte is
// registered, then decoded by the parser, and its event is loaded into the result register
// the byte register stalls only while the result register holds an untaken event
// synchronous reset empties both registers, starts hunting and sets the limit to 3840
`timescale 1ns / 1ps
module ac3_syncframe_splitter #(
  parameter int unsigned LEAD_COUNT_MAX = 65535
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic [15:0] lead_bytes,
  output logic [11:0] frame_bytes,
  output logic [1:0]  rate_code,
  output logic [5:0]  size_code,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import ac3sf_pkg::*;

  logic       step;
  logic       out_room;
  logic [7:0] byte_q;
  logic       emit;
  result_t    result;
  result_t    result_q;

  ac3sf_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .out_room  (out_room),
    .step      (step),
    .byte_q    (byte_q)
  );

  ac3sf_parser #(
    .LEAD_COUNT_MAX (LEAD_COUNT_MAX)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (step),
    .byte_q      (byte_q),
    .emit        (emit),
    .result      (result)
  );

  ac3sf_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (step & emit),
    .result    (result),
    .out_room  (out_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_q  (result_q)
  );

  assign event_kind  = result_q.event_kind;
  assign lead_bytes  = result_q.lead_bytes;
  assign frame_bytes = result_q.frame_bytes;
  assign rate_code   = result_q.rate_code;
  assign size_code   = result_q.size_code;

endmodule

// ===== rtl/ac3sf_checker.sv =====
// ac3sf_checker: port-level assertions for the ac-3 sync frame splitter, with its bind
`timescale 1ns / 1ps
module ac3sf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  event_kind,
  input logic [11:0] frame_bytes,
  input logic [1:0]  rate_code,
  input logic [5:0]  size_code
);
  import ac3sf_pkg::*;

  // byte register is empty right after reset
  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  a_bad_has_no_length: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == EV_BAD) |-> frame_bytes == 12'd0)
    else $error("bad header beat carries a frame length");

  a_frame_codes_legal: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_kind == EV_DONE || event_kind == EV_BIG)) |->
      (frame_bytes != 12'd0 && rate_code != RATE_RESERVED && size_code <= SIZE_CODE_LAST))
    else $error("frame beat with reserved codes or zero length");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_kind == EV_DONE || event_kind == EV_BAD || event_kind == EV_BIG))
    else $error("undefined event kind");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(event_kind) && $stable(frame_bytes)))
    else $error("stalled result beat changed");

endmodule

bind ac3_syncframe_splitter ac3sf_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .event_kind  (event_kind),
  .frame_bytes (frame_bytes),
  .rate_code   (rate_code),
  .size_code   (size_code)
);
